### rtl/steau_pkg.sv
// Package for the sparse tensor element access unit.
// Holds request and status codes, defaults and the controller/datapath structs.
package steau_pkg;

  localparam int unsigned DEF_MAX_RANK = 8;
  localparam int unsigned DEF_MAX_LIST = 64;
  localparam int unsigned DEF_CAPACITY = 4096;
  localparam int unsigned DEF_ID_BITS  = 12;

  localparam int unsigned FIELD_ID_W = 12;
  localparam int unsigned ADDR_OUT_W = 12;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_BEYOND  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX = 1'd1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic clr_step;  // clear one element store row
    logic append;    // do the append
    logic srch_init; // start search of current dim
    logic srch_step; // compare one list entry
    logic fold;      // fold found position into address
    logic next_dim;  // advance dimension
    logic mem_op;    // issue element store access
    logic done;      // present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic srch_hit;
    logic srch_end;
    logic dims_done;
    logic beyond;
  } dp_stat_t;

endpackage

### rtl/steau_datapath.sv
// Datapath of the sparse tensor element access unit: id lists, search,
// address fold and element store. Depends on steau_pkg.
module steau_datapath #(
  parameter int unsigned MAX_RANK = steau_pkg::DEF_MAX_RANK,
  parameter int unsigned MAX_LIST = steau_pkg::DEF_MAX_LIST,
  parameter int unsigned CAPACITY = steau_pkg::DEF_CAPACITY,
  parameter int unsigned ID_BITS  = steau_pkg::DEF_ID_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  steau_pkg::dp_cmd_t                           cmd,
  output steau_pkg::dp_stat_t                          stat,
  input  logic [1:0]                                   in_req_type,
  input  logic [2:0]                                   in_dim,
  input  logic [8*steau_pkg::FIELD_ID_W-1:0]           in_idx_flat,
  input  logic [steau_pkg::WORD_W-1:0]                 in_value_re,
  input  logic [steau_pkg::WORD_W-1:0]                 in_value_im,
  input  logic [3:0]                                   rank_r,
  input  logic                                         complex_r,
  output logic [1:0]                                   out_status,
  output logic [steau_pkg::ADDR_OUT_W-1:0]             out_element_address,
  output logic [steau_pkg::WORD_W-1:0]                 out_data_re,
  output logic [steau_pkg::WORD_W-1:0]                 out_data_im
);
  import steau_pkg::*;

  localparam int unsigned DW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned PW  = $clog2(MAX_LIST);
  localparam int unsigned LW  = $clog2(MAX_LIST + 1);
  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned LMW = $clog2(MAX_RANK * MAX_LIST);
  localparam int unsigned RW  = $clog2(MAX_RANK + 1);
  localparam int unsigned PRW = AW + LW; // product width

  logic [LW-1:0]      len_r [MAX_RANK];
  logic [ID_BITS-1:0] id_mem [MAX_RANK*MAX_LIST];
  logic [WORD_W-1:0]  re_mem [CAPACITY];
  logic [WORD_W-1:0]  im_mem [CAPACITY];

  logic [1:0]            req_r;
  logic [2:0]            dim_r;
  logic [8*FIELD_ID_W-1:0] idx_r;
  logic [WORD_W-1:0]     vre_r, vim_r;
  logic [RW-1:0]         nrank_r;
  logic [RW-1:0]         d_r;
  logic [LW-1:0]         k_r;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         clr_r;
  logic                  beyond_r;
  logic [ID_BITS-1:0]    rd_id_r;
  logic                  rd_vld_r;
  logic [PW-1:0]         pos_r;
  logic [1:0]            st_r;
  logic [WORD_W-1:0]     rre_r, rim_r;

  logic [ID_BITS-1:0]    want_id;
  logic [PRW-1:0]        prod;
  logic [LW-1:0]         len_cur;
  logic [LMW-1:0]        rd_addr;
  logic [DW-1:0]         app_dim;
  logic [DW-1:0]         d_idx;
  logic [RW-1:0]         rank_sat;

  assign rank_sat = (rank_r > 4'(MAX_RANK)) ? RW'(MAX_RANK) : RW'(rank_r);
  assign d_idx    = d_r[DW-1:0];
  assign want_id  = ID_BITS'(idx_r[FIELD_ID_W*32'(d_idx) +: FIELD_ID_W]);
  assign len_cur  = len_r[d_idx];
  assign rd_addr  = LMW'({d_idx, k_r[PW-1:0]});
  assign app_dim  = dim_r[DW-1:0];
  assign prod     = PRW'(addr_r) * PRW'(len_cur) + PRW'(pos_r);

  assign stat.clr_last  = (clr_r == AW'(CAPACITY - 1));
  assign stat.srch_hit  = rd_vld_r && (rd_id_r == want_id);
  assign stat.srch_end  = (k_r >= len_cur) && !rd_vld_r;
  assign stat.dims_done = (d_r >= nrank_r);
  assign stat.beyond    = beyond_r;

  // id list memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.append && {1'b0, dim_r} < 4'(MAX_RANK) && len_r[app_dim] < LW'(MAX_LIST))
      id_mem[LMW'({app_dim, len_r[app_dim][PW-1:0]})] <= ID_BITS'(idx_r[FIELD_ID_W-1:0]);
    rd_id_r <= id_mem[rd_addr];
  end

  // element store
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      re_mem[clr_r] <= '0;
      im_mem[clr_r] <= '0;
    end else if (cmd.mem_op && req_r == REQ_WRITE && st_r == ST_OK) begin
      re_mem[addr_r] <= vre_r;
      im_mem[addr_r] <= complex_r ? vim_r : '0;
    end
    rre_r <= re_mem[addr_r];
    rim_r <= im_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_RANK; i++) len_r[i] <= '0;
      clr_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_status <= '0;
      out_element_address <= '0;
      out_data_re <= '0;
      out_data_im <= '0;
    end else begin
      rd_vld_r <= 1'b0;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.load) begin
        req_r   <= in_req_type;
        dim_r   <= in_dim;
        idx_r   <= in_idx_flat;
        vre_r   <= in_value_re;
        vim_r   <= in_value_im;
        nrank_r <= rank_sat;
        d_r     <= '0;
        addr_r  <= '0;
        beyond_r <= 1'b0;
        st_r    <= ST_OK;
      end
      if (cmd.append) begin
        if ({1'b0, dim_r} >= 4'(MAX_RANK) || len_r[app_dim] >= LW'(MAX_LIST)) st_r <= ST_FULL;
        else len_r[app_dim] <= len_r[app_dim] + 1'b1;
      end
      if (cmd.srch_init) begin
        k_r <= '0;
      end
      // issue one list read per cycle, compare on the following cycle
      if (cmd.srch_step) begin
        if (stat.srch_hit) begin
          // hold pos_r for the fold
        end else if (k_r < len_cur) begin
          rd_vld_r <= 1'b1;
          pos_r    <= k_r[PW-1:0];
          k_r      <= k_r + 1'b1;
        end else begin
          st_r <= ST_ABSENT;
        end
      end
      if (cmd.fold) begin
        if (prod >= PRW'(CAPACITY)) begin
          beyond_r <= 1'b1;
          st_r <= ST_BEYOND;
        end
        addr_r <= prod[AW-1:0];
      end
      if (cmd.next_dim) d_r <= d_r + 1'b1;
      if (cmd.done) begin
        out_status <= st_r;
        out_element_address <= (st_r == ST_OK && (req_r == REQ_WRITE || req_r == REQ_READ)) ?
                               ADDR_OUT_W'(addr_r) : '0;
        if (st_r == ST_OK && req_r == REQ_READ) begin
          out_data_re <= rre_r;
          out_data_im <= complex_r ? rim_r : '0;
        end else begin
          out_data_re <= '0;
          out_data_im <= '0;
        end
      end
    end
  end

endmodule

### rtl/steau_ctrl.sv
// Controller of the sparse tensor element access unit: sequences clear, append,
// search, fold and store access. Depends on steau_pkg.
module steau_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_req_type,
  input  steau_pkg::dp_stat_t stat,
  output steau_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);
  import steau_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_APPEND, S_DIM, S_SEARCH, S_FOLD, S_MEM, S_MEMWAIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          priority if (in_req_type == REQ_APPEND) state_nxt = S_APPEND;
          else if (in_req_type == REQ_NONE) state_nxt = S_DONE;
          else state_nxt = S_DIM;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt = S_DONE;
      end
      S_DIM: begin
        if (stat.dims_done) state_nxt = S_MEM;
        else begin
          cmd.srch_init = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (stat.srch_hit) state_nxt = S_FOLD;
        else if (stat.srch_end) state_nxt = S_DONE;
      end
      S_FOLD: begin
        // once beyond capacity, keep searching for absent ids only
        cmd.fold = !stat.beyond;
        cmd.next_dim = 1'b1;
        state_nxt = S_DIM;
      end
      S_MEM: begin
        cmd.mem_op = 1'b1;
        state_nxt = S_MEMWAIT;
      end
      S_MEMWAIT: state_nxt = S_DONE;
      S_DONE: begin
        cmd.done = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= out_valid_nxt;
    end
  end

endmodule

### rtl/sparse_tensor_element_access_unit.sv
// Top level of the sparse tensor element access unit.
// Instantiates steau_ctrl and steau_datapath; depends on steau_pkg.
//
//  channel | handshake        | payload
//  in      | start / busy     | in_req_type, in_dim, in_idx_0..7, in_value_re/im
//  out     | out_valid strobe | out_status, out_element_address, out_data_re/im
//  cfg     | cfg_we           | cfg_index, cfg_data
//
// After reset the element store is cleared one entry a cycle, with busy high.
// An access searches the id list of each dimension, with one list read per
// cycle, and folds the found positions into the element address.
// Results are a one-cycle out_valid pulse; the receiver cannot stall.
module sparse_tensor_element_access_unit #(
  parameter int unsigned MAX_RANK = steau_pkg::DEF_MAX_RANK,
  parameter int unsigned MAX_LIST = steau_pkg::DEF_MAX_LIST,
  parameter int unsigned CAPACITY = steau_pkg::DEF_CAPACITY,
  parameter int unsigned ID_BITS  = steau_pkg::DEF_ID_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_req_type,
  input  logic [2:0]                          in_dim,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_0,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_1,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_2,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_3,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_4,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_5,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_6,
  input  logic [steau_pkg::FIELD_ID_W-1:0]    in_idx_7,
  input  logic [steau_pkg::WORD_W-1:0]        in_value_re,
  input  logic [steau_pkg::WORD_W-1:0]        in_value_im,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [steau_pkg::ADDR_OUT_W-1:0]    out_element_address,
  output logic [steau_pkg::WORD_W-1:0]        out_data_re,
  output logic [steau_pkg::WORD_W-1:0]        out_data_im,
  input  logic                                cfg_we,
  input  logic [steau_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [steau_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import steau_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [3:0] rank_r;
  logic       complex_r;
  logic [8*FIELD_ID_W-1:0] idx_flat;

  // idx_0 sits in the low field
  assign idx_flat = {in_idx_7, in_idx_6, in_idx_5, in_idx_4,
                     in_idx_3, in_idx_2, in_idx_1, in_idx_0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= 4'd4;
      complex_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANK:    rank_r <= cfg_data;
        CFG_COMPLEX: complex_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  steau_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_req_type, .stat, .cmd, .busy, .out_valid
  );

  steau_datapath #(
    .MAX_RANK(MAX_RANK), .MAX_LIST(MAX_LIST), .CAPACITY(CAPACITY), .ID_BITS(ID_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_req_type, .in_dim, .in_idx_flat(idx_flat),
    .in_value_re, .in_value_im, .rank_r, .complex_r,
    .out_status, .out_element_address, .out_data_re, .out_data_im
  );

`ifndef SYNTH
  a_start_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while still busy");
  a_data_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_data_re == '0 && out_element_address == '0))
    else $error("error result carries data");
`endif

endmodule
